/* rtl/name_escape_codec_assert.svh */
// Assertion helpers used by the codec top level.
`ifndef NAME_ESCAPE_CODEC_ASSERT_SVH
`define NAME_ESCAPE_CODEC_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define NEC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that, once seen, forces another one at the next edge.
`define NEC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/nec_pkg.sv */
package nec_pkg;

    localparam logic [7:0] ESC_CHAR   = 8'h5F;
    localparam logic [7:0] CASE_GAP   = 8'h20;
    localparam logic [7:0] DIGIT_ZERO = 8'h30;
    localparam logic [7:0] DIGIT_NINE = 8'h39;
    localparam logic [7:0] UPPER_A    = 8'h41;
    localparam logic [7:0] UPPER_Z    = 8'h5A;

    localparam int unsigned MAX_BURST = 4;

    typedef enum logic [1:0] {
        PH_TEXT = 2'd0,
        PH_ESC  = 2'd1,
        PH_DIG1 = 2'd2,
        PH_DIG2 = 2'd3
    } phase_t;

    typedef struct packed {
        logic [MAX_BURST-1:0][7:0] bytes;
        logic [2:0]                count;
        logic                      err;
        phase_t                    phase;
        logic [7:0]                acc;
    } step_res_t;

endpackage

/* rtl/nec_xlate.sv */
module nec_xlate
(
    input  logic [7:0]          char_in,
    input  logic                direction,
    input  nec_pkg::phase_t     phase,
    input  logic [7:0]          acc,
    output nec_pkg::step_res_t  res
);

    logic [7:0] digit;
    logic       special;

    assign digit = char_in - nec_pkg::DIGIT_ZERO;

    always_comb
    begin
        special = char_in inside {8'h5F, 8'h5C, 8'h2F, 8'h3A, 8'h3B, 8'h20, 8'h2A,
                                  8'h3F, 8'h7E, 8'h7C, 8'h3E, 8'h3C, 8'h2C, 8'h2B,
                                  8'h3D, 8'h40, 8'h25, 8'h26, 8'h21, 8'h2D};
    end

    always_comb
    begin
        res.bytes = '0;
        res.count = 3'd0;
        res.err   = 1'b0;
        res.phase = phase;
        res.acc   = acc;

        if (char_in == 8'h00)
        begin
            // End of name: emit the terminator and drop any escape in flight.
            res.count = 3'd1;
            res.err   = direction && (phase != nec_pkg::PH_TEXT);
            res.phase = nec_pkg::PH_TEXT;
            res.acc   = 8'h00;
        end
        else if (!direction)
        begin
            if (special)
            begin
                res.bytes[0] = nec_pkg::ESC_CHAR;
                res.bytes[1] = {5'b00110, char_in[7:6] == 2'b00 ? 3'b000 : {1'b0, char_in[7:6]}};
                res.bytes[2] = {5'b00110, char_in[5:3]};
                res.bytes[3] = {5'b00110, char_in[2:0]};
                res.count    = 3'd4;
            end
            else if (char_in >= nec_pkg::UPPER_A && char_in <= nec_pkg::UPPER_Z)
            begin
                res.bytes[0] = nec_pkg::ESC_CHAR;
                res.bytes[1] = char_in + nec_pkg::CASE_GAP;
                res.count    = 3'd2;
            end
            else
            begin
                res.bytes[0] = char_in;
                res.count    = 3'd1;
            end
        end
        else
        begin
            case (phase)
                nec_pkg::PH_TEXT:
                begin
                    if (char_in == nec_pkg::ESC_CHAR)
                    begin
                        res.phase = nec_pkg::PH_ESC;
                    end
                    else
                    begin
                        res.bytes[0] = char_in;
                        res.count    = 3'd1;
                    end
                end
                nec_pkg::PH_ESC:
                begin
                    if (char_in >= nec_pkg::DIGIT_ZERO && char_in <= nec_pkg::DIGIT_NINE)
                    begin
                        res.acc   = {digit[1:0], 6'b000000};
                        res.phase = nec_pkg::PH_DIG1;
                    end
                    else
                    begin
                        res.bytes[0] = char_in - nec_pkg::CASE_GAP;
                        res.count    = 3'd1;
                        res.phase    = nec_pkg::PH_TEXT;
                    end
                end
                nec_pkg::PH_DIG1:
                begin
                    res.acc   = acc + {digit[4:0], 3'b000};
                    res.phase = nec_pkg::PH_DIG2;
                end
                nec_pkg::PH_DIG2:
                begin
                    res.acc      = acc + digit;
                    res.bytes[0] = acc + digit;
                    res.count    = 3'd1;
                    res.phase    = nec_pkg::PH_TEXT;
                end
                default:
                begin
                    res.phase = nec_pkg::PH_TEXT;
                end
            endcase
        end
    end

endmodule

/* rtl/name_escape_codec.sv */
// Name escape codec: turns plain names into escaped form or back, one byte per request.
// Input channel s_*: one byte per request; a zero byte ends the name.
// Output channel m_*: one byte per request, tlast on the final byte caused by an input
// byte, tuser set on a terminator that closed the name inside an unfinished escape.
// direction_we/direction_wdata write the direction bit (0 encode, 1 decode); write it
// only while no bytes are in flight.
// An accepted byte is translated in the same cycle into a burst of zero to four result
// bytes held in a small burst register; the burst drains into the output register at
// one byte per cycle while the receiver keeps up, so each result byte passes through the
// burst register and then the output register on its way to m_*. Throughput is set by
// that single-byte output port: the input waits while a burst drains, so an encoded
// uppercase letter or special byte holds it longer than a plain byte. A new byte is
// taken in the cycle the last byte of the previous burst moves to the output register.
// Reset clears the direction bit to encode, the escape phase and accumulator, and
// empties the burst and output registers.
// When the receiver stalls, the output register holds its byte and the burst waits
// behind it; s_tready stays low until only the last burst byte is left and it can move.
`include "name_escape_codec_assert.svh"

module name_escape_codec
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] char_in

    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] char_out
    output logic       m_tlast,
    output logic       m_tuser,    // [0] escape_error

    input  logic       direction_we,
    input  logic       direction_wdata
);

    logic                                   direction_reg;
    nec_pkg::phase_t                        phase_reg;
    logic [7:0]                             acc_reg;

    logic [nec_pkg::MAX_BURST-1:0][7:0]     burst_data_reg;
    logic [2:0]                             burst_cnt_reg;
    logic                                   burst_err_reg;

    logic                                   m_valid_reg;
    logic [7:0]                             m_data_reg;
    logic                                   m_last_reg;
    logic                                   m_err_reg;

    nec_pkg::step_res_t                     step;
    logic                                   accept;
    logic                                   pop;

    nec_xlate u_xlate
    (
        .char_in   (s_tdata),
        .direction (direction_reg),
        .phase     (phase_reg),
        .acc       (acc_reg),
        .res       (step)
    );

    assign pop      = (burst_cnt_reg != 3'd0) && (!m_valid_reg || m_tready);
    assign s_tready = (burst_cnt_reg == 3'd0) || ((burst_cnt_reg == 3'd1) && pop);
    assign accept   = s_tvalid && s_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= 1'b0;
            phase_reg     <= nec_pkg::PH_TEXT;
            acc_reg       <= 8'h00;
            burst_cnt_reg <= 3'd0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            if (direction_we)
            begin
                direction_reg <= direction_wdata;
            end

            if (accept)
            begin
                phase_reg     <= step.phase;
                acc_reg       <= step.acc;
                burst_cnt_reg <= step.count;
            end
            else if (pop)
            begin
                burst_cnt_reg <= burst_cnt_reg - 3'd1;
            end

            if (pop)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: the burst shifts toward its head as bytes leave.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            burst_data_reg <= step.bytes;
            burst_err_reg  <= step.err;
        end
        else if (pop)
        begin
            for (int i = 0; i < nec_pkg::MAX_BURST - 1; i++)
            begin
                burst_data_reg[i] <= burst_data_reg[i+1];
            end
        end

        if (pop)
        begin
            m_data_reg <= burst_data_reg[0];
            m_last_reg <= (burst_cnt_reg == 3'd1);
            m_err_reg  <= burst_err_reg && (burst_cnt_reg == 3'd1);
        end
    end

    `NEC_ASSERT_ALWAYS(a_burst_bound, burst_cnt_reg <= 3'd4, "burst count out of range")
    `NEC_ASSERT_ALWAYS(a_ready_only_near_empty, !s_tready || burst_cnt_reg <= 3'd1,
        "input ready while a burst still has bytes to drain")
    `NEC_ASSERT_NEXT(a_drain_step, pop && burst_cnt_reg > 3'd1,
        burst_cnt_reg == $past(burst_cnt_reg) - 3'd1, "burst did not drain by one byte")
    `NEC_ASSERT_ALWAYS(a_error_on_last, !(m_tvalid && m_tuser) || m_tlast,
        "escape error flagged on a byte that is not the last")

endmodule

/* tb/tb_top.sv */
module tb_top;

    localparam int CYCLE_LIMIT = 400000;
    localparam int TOTAL_ITEMS = 460;
    localparam int SETTLE      = 8;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       err;
    } out_byte_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;    // [7:0] char_in
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [7:0] char_out
    logic       m_tlast;
    logic       m_tuser;            // [0] escape_error
    logic       direction_we = 1'b0;
    logic       direction_wdata = 1'b0;

    int send_idle = 0;
    int recv_idle = 0;
    int items_sent = 0;
    int cycles = 0;

    function automatic logic [7:0] special_byte(int k);
        case (k)
            0:       return nec_pkg::ESC_CHAR;
            1:       return "\\";
            2:       return "/";
            3:       return ":";
            4:       return ";";
            5:       return " ";
            6:       return "*";
            7:       return "?";
            8:       return "~";
            9:       return "|";
            10:      return ">";
            11:      return "<";
            12:      return ",";
            13:      return "+";
            14:      return "=";
            15:      return "@";
            16:      return "%";
            17:      return "&";
            18:      return "!";
            19:      return "-";
            default: return 8'h00;
        endcase
    endfunction

    class escape_codec_shadow;
        logic            dir;
        nec_pkg::phase_t phase;
        logic [7:0]      acc;
        out_byte_t       owed_bytes[$];
        int              mismatches;

        function new();
            dir = 1'b0;
            phase = nec_pkg::PH_TEXT;
            acc = 8'h00;
            mismatches = 0;
        endfunction

        function void owe(logic [7:0] ch, logic last, logic err);
            out_byte_t o;
            o.ch = ch;
            o.last = last;
            o.err = err;
            owed_bytes.push_back(o);
        endfunction

        function int outstanding();
            return owed_bytes.size();
        endfunction

        function void write_direction(logic v);
            dir = v;
        endfunction

        // Works out the bytes that one accepted input request is due to produce.
        function void translate_request(logic [7:0] c);
            logic [7:0] d;
            logic       special;
            d = c - nec_pkg::DIGIT_ZERO;
            special = 1'b0;
            for (int k = 0; k < 20; k++)
            begin
                if (special_byte(k) == c)
                    special = 1'b1;
            end
            if (c == 8'h00)
            begin
                owe(8'h00, 1'b1, dir && (phase != nec_pkg::PH_TEXT));
                phase = nec_pkg::PH_TEXT;
                acc = 8'h00;
            end
            else if (!dir)
            begin
                if (special)
                begin
                    owe(nec_pkg::ESC_CHAR, 1'b0, 1'b0);
                    owe({6'd0, c[7:6]} + nec_pkg::DIGIT_ZERO, 1'b0, 1'b0);
                    owe({5'd0, c[5:3]} + nec_pkg::DIGIT_ZERO, 1'b0, 1'b0);
                    owe({5'd0, c[2:0]} + nec_pkg::DIGIT_ZERO, 1'b1, 1'b0);
                end
                else if (c >= nec_pkg::UPPER_A && c <= nec_pkg::UPPER_Z)
                begin
                    owe(nec_pkg::ESC_CHAR, 1'b0, 1'b0);
                    owe(c + nec_pkg::CASE_GAP, 1'b1, 1'b0);
                end
                else
                    owe(c, 1'b1, 1'b0);
            end
            else
            begin
                case (phase)
                    nec_pkg::PH_TEXT:
                    begin
                        if (c == nec_pkg::ESC_CHAR)
                            phase = nec_pkg::PH_ESC;
                        else
                            owe(c, 1'b1, 1'b0);
                    end
                    nec_pkg::PH_ESC:
                    begin
                        if (c >= nec_pkg::DIGIT_ZERO && c <= nec_pkg::DIGIT_NINE)
                        begin
                            acc = d << 6;
                            phase = nec_pkg::PH_DIG1;
                        end
                        else
                        begin
                            phase = nec_pkg::PH_TEXT;
                            owe(c - nec_pkg::CASE_GAP, 1'b1, 1'b0);
                        end
                    end
                    nec_pkg::PH_DIG1:
                    begin
                        // Digits after the first are not checked; any byte adds its weight.
                        acc = acc + (d << 3);
                        phase = nec_pkg::PH_DIG2;
                    end
                    default:
                    begin
                        acc = acc + d;
                        phase = nec_pkg::PH_TEXT;
                        owe(acc, 1'b1, 1'b0);
                    end
                endcase
            end
        endfunction

        function void match_output_byte(logic [7:0] ch, logic last, logic err);
            out_byte_t o;
            if (owed_bytes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output byte %02h last %0b err %0b", ch, last, err);
            end
            else
            begin
                o = owed_bytes.pop_front();
                if (o.ch !== ch || o.last !== last || o.err !== err)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected %02h last %0b err %0b, ",
                                  "got %02h last %0b err %0b"},
                                 o.ch, o.last, o.err, ch, last, err);
                end
            end
        endfunction
    endclass

    escape_codec_shadow shadow;

    name_escape_codec i_dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .m_tuser         (m_tuser),
        .direction_we    (direction_we),
        .direction_wdata (direction_wdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                shadow.match_output_byte(m_tdata, m_tlast, m_tuser);
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        shadow.translate_request(b);
        items_sent++;
    endtask

    // Holds the sender back until every owed byte has come out, then lets
    // a request that produces nothing finish inside the block.
    task drain_owed();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (shadow.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task set_direction(input logic v);
        drain_owed();
        direction_we <= 1'b1;
        direction_wdata <= v;
        @(posedge clk);
        shadow.write_direction(v);
        direction_we <= 1'b0;
    endtask

    task send_encode_name();
        int         n;
        int         r;
        logic [7:0] b;
        n = $urandom_range(1, 10);
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < 30)
                b = special_byte($urandom_range(19));
            else if (r < 55)
                b = 8'($urandom_range(nec_pkg::UPPER_A, nec_pkg::UPPER_Z));
            else
                b = 8'($urandom_range(1, 255));
            send_byte(b);
        end
        if ($urandom_range(9) != 0)
            send_byte(8'h00);
    endtask

    task send_decode_name();
        int         n;
        int         r;
        logic [7:0] b;
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < 35)
            begin
                b = 8'($urandom_range(1, 255));
                if (b == nec_pkg::ESC_CHAR)
                    b = 8'h60;
                send_byte(b);
            end
            else if (r < 55)
            begin
                send_byte(nec_pkg::ESC_CHAR);
                if (r < 50)
                    send_byte(8'($urandom_range("a", "z")));
                else
                    send_byte(8'($urandom_range(1, 255)));
            end
            else if (r < 88)
            begin
                send_byte(nec_pkg::ESC_CHAR);
                send_byte(nec_pkg::DIGIT_ZERO + 8'($urandom_range(3)));
                // Mostly octal digits, now and then 8, 9 or any byte at all.
                for (int k = 0; k < 2; k++)
                begin
                    r = $urandom_range(99);
                    if (r < 85)
                        send_byte(nec_pkg::DIGIT_ZERO + 8'($urandom_range(7)));
                    else if (r < 93)
                        send_byte(nec_pkg::DIGIT_ZERO + 8'($urandom_range(8, 9)));
                    else
                        send_byte(8'($urandom_range(255)));
                end
            end
            else if (r < 94)
            begin
                // The name breaks off inside an escape.
                send_byte(nec_pkg::ESC_CHAR);
                if ($urandom_range(1))
                    send_byte(nec_pkg::DIGIT_ZERO + 8'($urandom_range(9)));
                if ($urandom_range(1))
                    send_byte(nec_pkg::DIGIT_ZERO + 8'($urandom_range(7)));
                send_byte(8'h00);
            end
            else
                send_byte(8'($urandom_range(255)));
        end
        if ($urandom_range(9) != 0)
            send_byte(8'h00);
    endtask

    initial
    begin
        int target;
        shadow = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Encoding after reset: extremes, letters at both ends, specials, high bytes.
        send_byte(8'hFF);
        send_byte(nec_pkg::UPPER_A);
        send_byte(nec_pkg::UPPER_Z);
        send_byte(nec_pkg::ESC_CHAR);
        send_byte("-");
        send_byte(8'h80);
        send_byte(8'h00);

        set_direction(1'b1);
        send_byte(nec_pkg::ESC_CHAR);
        send_byte("1");
        send_byte("4");
        send_byte("1");
        send_byte(nec_pkg::ESC_CHAR);
        send_byte("a");
        send_byte(nec_pkg::ESC_CHAR);
        send_byte("9");
        send_byte("9");
        send_byte("9");
        send_byte(nec_pkg::ESC_CHAR);
        send_byte("1");
        send_byte("x");
        send_byte("y");
        send_byte(nec_pkg::ESC_CHAR);
        send_byte(8'h00);

        // An escape left open across a switch to encoding is still open afterwards.
        send_byte(nec_pkg::ESC_CHAR);
        set_direction(1'b0);
        send_byte("b");
        set_direction(1'b1);
        send_byte(8'h05);
        send_byte(8'h00);

        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle = 18;
                    recv_idle = 69;
                end
                1:
                begin
                    send_idle = 69;
                    recv_idle = 18;
                end
                default:
                begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            target = (TOTAL_ITEMS * (ph + 1)) / 3;
            while (items_sent < target)
            begin
                set_direction(1'($urandom_range(1)));
                repeat ($urandom_range(1, 4))
                begin
                    if (shadow.dir)
                        send_decode_name();
                    else
                        send_encode_name();
                    if ($urandom_range(19) == 0)
                        drain_owed();
                end
            end
        end

        drain_owed();
        repeat (20) @(posedge clk);
        if (shadow.mismatches == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end
endmodule
